// ===== sv/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds in the same cycle as the trigger
`define ASSERT_NOW(label, clk, rst_n, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("assertion failed");

// condition holds in the cycle after the trigger
`define ASSERT_NEXT(label, clk, rst_n, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("assertion failed");

`endif

// ===== sv/owbm_pkg.sv =====
// shared types and constants of the single-wire bus master
`default_nettype none

package owbm_pkg;

  localparam int CounterWidthDefault = 16;
  localparam int CfgWidth = 16;
  localparam int CfgCount = 6;
  localparam int CfgIndexWidth = 3;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_RESET = 2'd1,
    MODE_WRITE = 2'd2,
    MODE_READ  = 2'd3
  } mode_e;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_RESET_LOW     = 3'd0,
    CFG_PRESENCE_WAIT = 3'd1,
    CFG_RESET_TAIL    = 3'd2,
    CFG_SLOT_START    = 3'd3,
    CFG_READ_SAMPLE   = 3'd4,
    CFG_SLOT          = 3'd5
  } cfg_idx_e;

  typedef logic [CfgWidth-1:0] cfg_word_t;

  localparam cfg_word_t CfgResetVal [CfgCount] = '{
    16'd480, 16'd70, 16'd410, 16'd2, 16'd13, 16'd70
  };

endpackage

`default_nettype wire

// ===== sv/onewire_bus_master_unit.sv =====
// single-wire bus master: one tick per item, timing from tick-count registers
//
//  channel   direction  handshake                 payload
//  s_axis    in         s_axis_tvalid/tready      tick: mode, wr_byte, line_level
//  m_axis    out        m_axis_tvalid/tready      drive_low, busy, done, presence, rd_byte
//  cfg       in         cfg_valid/cfg_ready       register index, 16-bit value
//
// one item is accepted per cycle; its result appears in the output register
// on the next cycle, set by the combinational state update that also loads the state.
// reset clears the state machine and loads default timing values.
// a stalled output holds its result; a new item is taken while the output
// is empty or being taken in the same cycle. configuration is always ready.
`default_nettype none

module onewire_bus_master_unit #(
  parameter int COUNTER_WIDTH = owbm_pkg::CounterWidthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [15:0] s_axis_tdata_i,   // wr_byte[7:0], line_level[8], zero fill
  input  wire logic [1:0]  s_axis_tuser_i,   // mode[1:0]
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o,   // drive_low, busy_res, done_res, presence,
                                             // rd_byte[11:4], zero fill
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [owbm_pkg::CfgIndexWidth-1:0] cfg_index_i,
  input  wire logic [owbm_pkg::CfgWidth-1:0]      cfg_data_i
);

  localparam int CMPW = ((COUNTER_WIDTH > owbm_pkg::CfgWidth) ?
                         COUNTER_WIDTH : owbm_pkg::CfgWidth) + 1;
  localparam logic [COUNTER_WIDTH-1:0] CntMax = '1;
  localparam logic [CMPW-1:0] CntMaxX = {{(CMPW-COUNTER_WIDTH){1'b0}}, CntMax};

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_RST_LOW  = 3'd1,
    PH_RST_WAIT = 3'd2,
    PH_RST_TAIL = 3'd3,
    PH_SLOT     = 3'd4
  } phase_e;

  owbm_pkg::cfg_word_t cfg_q [owbm_pkg::CfgCount];

  phase_e                   phase_q, phase_d;
  owbm_pkg::mode_e          op_q, op_d;
  logic [COUNTER_WIDTH-1:0] tick_q, tick_d;
  logic [2:0]               bit_q, bit_d;
  logic [7:0]               shift_q, shift_d;
  logic                     pres_q, pres_d;
  logic [7:0]               last_q, last_d;

  logic                     out_valid_q;
  logic [15:0]              out_data_q;

  owbm_pkg::mode_e          mode;
  logic [7:0]               wr_byte;
  logic                     line_level;
  logic                     s_accept;
  logic                     drive, busy, done;
  logic [CMPW-1:0]          tick_x, last_x, sp_x, start_x;
  owbm_pkg::cfg_word_t      slot_len;

  function automatic logic ends_f(logic [CMPW-1:0] t, logic [CMPW-1:0] len);
    return ((t + CMPW'(1)) >= len) || (t == CntMaxX);
  endfunction

  assign mode       = owbm_pkg::mode_e'(s_axis_tuser_i);
  assign wr_byte    = s_axis_tdata_i[7:0];
  assign line_level = s_axis_tdata_i[8];

  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign cfg_ready_o     = 1'b1;

  always_comb begin
    phase_d  = phase_q;
    op_d     = op_q;
    tick_d   = tick_q;
    bit_d    = bit_q;
    shift_d  = shift_q;
    pres_d   = pres_q;
    last_d   = last_q;
    drive    = 1'b0;
    busy     = 1'b0;
    done     = 1'b0;
    last_x   = '0;
    sp_x     = '0;
    start_x  = CMPW'(cfg_q[owbm_pkg::CFG_SLOT_START]);
    slot_len = (cfg_q[owbm_pkg::CFG_SLOT] != '0) ?
               cfg_q[owbm_pkg::CFG_SLOT] : owbm_pkg::CfgWidth'(1);

    // command start in idle counts as the first tick
    if (phase_q == PH_IDLE && mode != owbm_pkg::MODE_TICK) begin
      op_d   = mode;
      tick_d = '0;
      bit_d  = '0;
      if (mode == owbm_pkg::MODE_RESET) begin
        phase_d = PH_RST_LOW;
      end else begin
        phase_d = PH_SLOT;
        shift_d = (mode == owbm_pkg::MODE_WRITE) ? wr_byte : 8'h00;
      end
    end

    tick_x = CMPW'(tick_d);

    case (phase_d)
      PH_IDLE: begin
        phase_d = PH_IDLE;
      end
      PH_RST_LOW: begin
        drive = 1'b1;
        busy  = 1'b1;
        if (ends_f(tick_x, CMPW'(cfg_q[owbm_pkg::CFG_RESET_LOW]))) begin
          phase_d = PH_RST_WAIT;
          tick_d  = '0;
        end else if (tick_d != CntMax) begin
          tick_d = tick_d + 1'b1;
        end
      end
      PH_RST_WAIT: begin
        busy = 1'b1;
        if (ends_f(tick_x, CMPW'(cfg_q[owbm_pkg::CFG_PRESENCE_WAIT]))) begin
          pres_d  = !line_level;
          phase_d = PH_RST_TAIL;
          tick_d  = '0;
        end else if (tick_d != CntMax) begin
          tick_d = tick_d + 1'b1;
        end
      end
      PH_RST_TAIL: begin
        busy = 1'b1;
        if (ends_f(tick_x, CMPW'(cfg_q[owbm_pkg::CFG_RESET_TAIL]))) begin
          phase_d = PH_IDLE;
          op_d    = owbm_pkg::MODE_TICK;
          tick_d  = '0;
          bit_d   = '0;
          done    = 1'b1;
        end else if (tick_d != CntMax) begin
          tick_d = tick_d + 1'b1;
        end
      end
      PH_SLOT: begin
        busy   = 1'b1;
        last_x = CMPW'(slot_len - owbm_pkg::CfgWidth'(1));
        if (last_x > CntMaxX) begin
          last_x = CntMaxX;
        end
        if (op_d == owbm_pkg::MODE_WRITE) begin
          drive = (tick_x < start_x) || (!shift_d[0] && (tick_x < last_x));
        end else begin
          sp_x = (cfg_q[owbm_pkg::CFG_READ_SAMPLE] != '0) ?
                 CMPW'(cfg_q[owbm_pkg::CFG_READ_SAMPLE] - owbm_pkg::CfgWidth'(1)) : '0;
          if (sp_x > last_x) begin
            sp_x = last_x;
          end
          drive = (tick_x < start_x);
          if (tick_x == sp_x) begin
            shift_d = {line_level, shift_d[7:1]};
          end
        end
        if (ends_f(tick_x, CMPW'(slot_len))) begin
          if (op_d == owbm_pkg::MODE_WRITE) begin
            shift_d = {1'b0, shift_d[7:1]};
          end
          if (bit_d == 3'd7) begin
            if (op_d == owbm_pkg::MODE_READ) begin
              last_d = shift_d;
            end
            phase_d = PH_IDLE;
            op_d    = owbm_pkg::MODE_TICK;
            tick_d  = '0;
            bit_d   = '0;
            done    = 1'b1;
          end else begin
            bit_d  = bit_d + 3'd1;
            tick_d = '0;
          end
        end else if (tick_d != CntMax) begin
          tick_d = tick_d + 1'b1;
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      op_q        <= owbm_pkg::MODE_TICK;
      tick_q      <= '0;
      bit_q       <= '0;
      shift_q     <= '0;
      pres_q      <= 1'b0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (s_accept) begin
        phase_q     <= phase_d;
        op_q        <= op_d;
        tick_q      <= tick_d;
        bit_q       <= bit_d;
        shift_q     <= shift_d;
        pres_q      <= pres_d;
        last_q      <= last_d;
        out_valid_q <= 1'b1;
        out_data_q  <= {4'b0000, last_d, pres_d, done, busy, drive};
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < owbm_pkg::CfgCount; i++) begin
        cfg_q[i] <= owbm_pkg::CfgResetVal[i];
      end
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (owbm_pkg::cfg_idx_e'(cfg_index_i))
        owbm_pkg::CFG_RESET_LOW:     cfg_q[owbm_pkg::CFG_RESET_LOW]     <= cfg_data_i;
        owbm_pkg::CFG_PRESENCE_WAIT: cfg_q[owbm_pkg::CFG_PRESENCE_WAIT] <= cfg_data_i;
        owbm_pkg::CFG_RESET_TAIL:    cfg_q[owbm_pkg::CFG_RESET_TAIL]    <= cfg_data_i;
        owbm_pkg::CFG_SLOT_START:    cfg_q[owbm_pkg::CFG_SLOT_START]    <= cfg_data_i;
        owbm_pkg::CFG_READ_SAMPLE:   cfg_q[owbm_pkg::CFG_READ_SAMPLE]   <= cfg_data_i;
        owbm_pkg::CFG_SLOT:          cfg_q[owbm_pkg::CFG_SLOT]          <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/owbm_checker.sv =====
// port-level checks of the single-wire bus master and their bind
`default_nettype none
`include "assert_macros.svh"

module owbm_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic [15:0] s_axis_tdata_i,
  input wire logic [1:0]  s_axis_tuser_i,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [15:0] m_axis_tdata_o,
  input wire logic        cfg_valid_i,
  input wire logic        cfg_ready_o,
  input wire logic [2:0]  cfg_index_i,
  input wire logic [15:0] cfg_data_i
);

  logic in_acc;
  logic out_stall;

  assign in_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign out_stall = m_axis_tvalid_o && !m_axis_tready_i;

  // every accepted tick yields a result next cycle
  `ASSERT_NEXT(a_tick_result, clk_i, rst_ni, in_acc, m_axis_tvalid_o)
  // an empty output never blocks the input
  `ASSERT_NOW(a_ready_when_empty, clk_i, rst_ni, !m_axis_tvalid_o, s_axis_tready_o)
  // a finishing tick is always a busy tick
  `ASSERT_NOW(a_done_busy, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tdata_o[2],
              m_axis_tdata_o[1])
  // stalled result holds
  `ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, out_stall,
               m_axis_tvalid_o && $stable(m_axis_tdata_o))

endmodule

bind onewire_bus_master_unit owbm_checker u_owbm_checker (.*);

`default_nettype wire
